FILE: rtl/rs_gf16_parity_encode_check_defines.svh
// Assertion macros shared by the queue and back RTL files of the GF(16) parity block.
`ifndef RS_GF16_PARITY_ENCODE_CHECK_DEFINES_SVH
`define RS_GF16_PARITY_ENCODE_CHECK_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every rising clock edge, masked while reset is high
`define RGPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising clock edge, reset included
`define RGPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGPC_ASSERT(lbl, clk, rst, prop, msg)
`define RGPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/rgpc_pkg.sv
`default_nettype none

package rgpc_pkg;

   // symbol and register sizes
   localparam int SYMBOL_BITS = 4;
   localparam int GEN_TAPS    = 8;
   localparam int GEN_BITS    = SYMBOL_BITS * GEN_TAPS;
   localparam int CSR_IDX_BITS = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_GENERATOR  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIELD_POLY = 2'd1;

   // reset values
   localparam logic [GEN_BITS-1:0]    GEN_RESET  = 32'h3394_C000;
   localparam logic [SYMBOL_BITS-1:0] POLY_RESET = 4'h3;

   // request action codes
   localparam logic ACT_ENCODE = 1'b0;
   localparam logic ACT_CHECK  = 1'b1;

   // job word layout in the queue: head bits, then the parity symbols
   localparam int JOB_SYM_LSB   = 0;
   localparam int JOB_LAST      = 4;
   localparam int JOB_OK        = 5;
   localparam int JOB_ACT       = 6;
   localparam int JOB_HEAD_BITS = 7;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // GF(16) product, reduced by x^4 + poly
   function automatic logic [SYMBOL_BITS-1:0] gf_mul(
      input logic [SYMBOL_BITS-1:0] a,
      input logic [SYMBOL_BITS-1:0] b,
      input logic [SYMBOL_BITS-1:0] poly
   );
      logic [SYMBOL_BITS-1:0] acc;
      acc = '0;
      for (int k = SYMBOL_BITS - 1; k >= 0; k--) begin
         acc = acc[SYMBOL_BITS-1] ? ({acc[SYMBOL_BITS-2:0], 1'b0} ^ poly)
                                  : {acc[SYMBOL_BITS-2:0], 1'b0};
         if (b[k]) begin
            acc = acc ^ a;
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rs_gf16_parity_encode_check.sv
`default_nettype none

// Reed-Solomon style GF(16) systematic encoder and codeword checker. Requests
// carry one 4-bit symbol, highest degree first. Encode requests echo the symbol;
// the last one of a message is followed by PARITY_SYMBOLS parity symbols,
// highest first. Check requests return nothing until the last one, which
// returns a single item with check_valid set when the codeword divides by the
// generator. The remainder LFSR updates all taps in parallel, so one request
// is taken per clock while a two-entry job queue has room; the response side
// delivers one item per clock while rsp_ready is high, so an encode request
// with last set holds the output for its echo and PARITY_SYMBOLS parity items,
// back-pressuring the queue. Items pass the job queue, job and output registers.
// Generator coefficients (csr index 0, g0 in bits 3:0, x^PARITY_SYMBOLS implied)
// and the low bits of the field polynomial (csr index 1, x^4 implied) must be
// written by the user only while the block is idle; this is not enforced.
module rs_gf16_parity_encode_check #(
   parameter int PARITY_SYMBOLS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [rgpc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [rgpc_pkg::GEN_BITS-1:0]     csr_wdata,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                              req_action,
   input  wire logic [rgpc_pkg::SYMBOL_BITS-1:0]  req_symbol_in,
   input  wire logic                              req_last_in,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [rgpc_pkg::SYMBOL_BITS-1:0]  rsp_symbol_out,
   output      logic                              rsp_is_parity,
   output      logic                              rsp_check_valid,
   output      logic                              rsp_last_out
);

   localparam int JOB_BITS = rgpc_pkg::JOB_HEAD_BITS
                             + rgpc_pkg::SYMBOL_BITS * PARITY_SYMBOLS;

   rgpc_pkg::q_stat_type  q_stat;
   logic                  q_push;
   logic                  q_pop;
   logic [JOB_BITS-1:0]   q_wr_data;
   logic [JOB_BITS-1:0]   q_rd_data;

   // request side: LFSR and job classification
   rgpc_front #(
      .PARITY_SYMBOLS (PARITY_SYMBOLS),
      .JOB_BITS       (JOB_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_symbol_in (req_symbol_in),
      .req_last_in   (req_last_in),
      .q_stat        (q_stat),
      .q_push        (q_push),
      .q_data        (q_wr_data)
   );

   // job queue
   rgpc_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .q_stat  (q_stat)
   );

   // response side
   rgpc_back #(
      .PARITY_SYMBOLS (PARITY_SYMBOLS),
      .JOB_BITS       (JOB_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_rd_data       (q_rd_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol_out  (rsp_symbol_out),
      .rsp_is_parity   (rsp_is_parity),
      .rsp_check_valid (rsp_check_valid),
      .rsp_last_out    (rsp_last_out)
   );

endmodule

`default_nettype wire

FILE: rtl/rgpc_queue.sv
`default_nettype none

`include "rs_gf16_parity_encode_check_defines.svh"

// Two-entry job queue between front and back
module rgpc_queue #(
   parameter int WIDTH = 39
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              pop,
   output      logic [WIDTH-1:0]  rd_data,
   output      rgpc_pkg::q_stat_type q_stat
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);

   `RGPC_ASSERT(a_no_push_full, clock, reset, push |-> !q_stat.full, "push into full queue")
   `RGPC_ASSERT(a_no_pop_empty, clock, reset, pop |-> !q_stat.empty, "pop from empty queue")
   `RGPC_ASSERT_ALWAYS(a_count_range, clock, reset || count_ff != 2'd3, "queue count out of range")

endmodule

`default_nettype wire

FILE: rtl/rgpc_front.sv
`default_nettype none

// Front: config registers, remainder LFSR, job classification
module rgpc_front #(
   parameter int PARITY_SYMBOLS = 8,
   parameter int JOB_BITS       = 39
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [rgpc_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [rgpc_pkg::GEN_BITS-1:0]          csr_wdata,
   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic                                   req_action,
   input  wire logic [rgpc_pkg::SYMBOL_BITS-1:0]       req_symbol_in,
   input  wire logic                                   req_last_in,
   input  wire rgpc_pkg::q_stat_type                   q_stat,
   output      logic                                   q_push,
   output      logic [JOB_BITS-1:0]                    q_data
);

   localparam int SB = rgpc_pkg::SYMBOL_BITS;

   logic [rgpc_pkg::GEN_BITS-1:0] gen_ff;
   logic [SB-1:0]                 poly_ff;
   logic [SB-1:0]                 rem_ff [PARITY_SYMBOLS];
   logic [SB-1:0]                 rem_in [PARITY_SYMBOLS];
   logic [SB-1:0]                 rem_nx [PARITY_SYMBOLS];
   logic [SB-1:0]                 coef   [PARITY_SYMBOLS];
   logic [SB-1:0]                 fb;
   logic                          is_check;
   logic                          accept;
   logic                          zero_rem;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= rgpc_pkg::GEN_RESET;
         poly_ff <= rgpc_pkg::POLY_RESET;
      end else if (csr_we) begin
         if (csr_index == rgpc_pkg::CSR_GENERATOR) begin
            gen_ff <= csr_wdata;
         end else if (csr_index == rgpc_pkg::CSR_FIELD_POLY) begin
            poly_ff <= csr_wdata[SB-1:0];
         end
      end
   end

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign is_check  = (req_action == rgpc_pkg::ACT_CHECK);

   // feedback: encode adds the symbol at the top, check shifts it in at the bottom
   assign fb = is_check ? rem_ff[PARITY_SYMBOLS-1]
                        : (req_symbol_in ^ rem_ff[PARITY_SYMBOLS-1]);

   // all taps update in parallel
   for (genvar i = 0; i < PARITY_SYMBOLS; i++) begin : g_tap
      if (i < rgpc_pkg::GEN_TAPS) begin : g_coef
         assign coef[i] = gen_ff[SB*i +: SB];
      end else begin : g_zero
         assign coef[i] = '0;
      end
      if (i == 0) begin : g_low
         assign rem_nx[i] = (is_check ? req_symbol_in : '0)
                            ^ rgpc_pkg::gf_mul(fb, coef[i], poly_ff);
      end else begin : g_up
         assign rem_nx[i] = rem_ff[i-1] ^ rgpc_pkg::gf_mul(fb, coef[i], poly_ff);
      end
   end

   always_comb begin
      zero_rem = 1'b1;
      for (int i = 0; i < PARITY_SYMBOLS; i++) begin
         if (rem_nx[i] != '0) begin
            zero_rem = 1'b0;
         end
         if (!accept) begin
            rem_in[i] = rem_ff[i];
         end else if (req_last_in) begin
            rem_in[i] = '0;
         end else begin
            rem_in[i] = rem_nx[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PARITY_SYMBOLS; i++) begin
            rem_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < PARITY_SYMBOLS; i++) begin
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   // job for the back: every encode request, and the last of a check run
   assign q_push = accept && (!is_check || req_last_in);

   always_comb begin
      q_data = '0;
      q_data[rgpc_pkg::JOB_SYM_LSB +: SB] = req_symbol_in;
      q_data[rgpc_pkg::JOB_LAST]          = req_last_in;
      q_data[rgpc_pkg::JOB_OK]            = zero_rem;
      q_data[rgpc_pkg::JOB_ACT]           = req_action;
      for (int i = 0; i < PARITY_SYMBOLS; i++) begin
         q_data[rgpc_pkg::JOB_HEAD_BITS + SB*i +: SB] = rem_nx[i];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rgpc_back.sv
`default_nettype none

`include "rs_gf16_parity_encode_check_defines.svh"

// Back: unrolls each job into response items behind an output register
module rgpc_back #(
   parameter int PARITY_SYMBOLS = 8,
   parameter int JOB_BITS       = 39
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rgpc_pkg::q_stat_type              q_stat,
   input  wire logic [JOB_BITS-1:0]               q_rd_data,
   output      logic                              q_pop,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [rgpc_pkg::SYMBOL_BITS-1:0]  rsp_symbol_out,
   output      logic                              rsp_is_parity,
   output      logic                              rsp_check_valid,
   output      logic                              rsp_last_out
);

   localparam int SB    = rgpc_pkg::SYMBOL_BITS;
   localparam int IDX_W = $clog2(PARITY_SYMBOLS + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PARITY_SYMBOLS);

   logic             job_vld_ff, job_vld_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             job_act_ff;
   logic             job_last_ff;
   logic             job_ok_ff;
   logic [SB-1:0]    job_sym_ff;
   logic [SB-1:0]    par_ff [PARITY_SYMBOLS];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]    rsp_sym_ff, rsp_sym_in;
   logic             rsp_par_ff, rsp_par_in;
   logic             rsp_chk_ff, rsp_chk_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_adv;
   logic             emit;
   logic             has_parity;
   logic             job_done;
   logic             load;
   logic             par_step;
   logic             final_par;

   // sequencing
   assign out_adv    = !rsp_valid_ff || rsp_ready;
   assign emit       = job_vld_ff && out_adv;
   assign has_parity = (job_act_ff == rgpc_pkg::ACT_ENCODE) && job_last_ff;
   assign job_done   = emit && ((idx_ff == IDX_LAST) || (idx_ff == '0 && !has_parity));
   assign load       = !q_stat.empty && (!job_vld_ff || job_done);
   assign q_pop      = load;
   assign par_step   = job_vld_ff && (idx_ff != '0);
   assign final_par  = emit && (idx_ff == IDX_LAST);

   always_comb begin
      job_vld_in = job_vld_ff;
      idx_in     = idx_ff;
      if (load) begin
         job_vld_in = 1'b1;
         idx_in     = '0;
      end else if (job_done) begin
         job_vld_in = 1'b0;
         idx_in     = '0;
      end else if (emit) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // next response item
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sym_in   = rsp_sym_ff;
      rsp_par_in   = rsp_par_ff;
      rsp_chk_in   = rsp_chk_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (idx_ff != '0) begin
            rsp_sym_in  = par_ff[PARITY_SYMBOLS-1];
            rsp_par_in  = 1'b1;
            rsp_chk_in  = 1'b0;
            rsp_last_in = (idx_ff == IDX_LAST);
         end else if (job_act_ff == rgpc_pkg::ACT_CHECK) begin
            rsp_sym_in  = '0;
            rsp_par_in  = 1'b0;
            rsp_chk_in  = job_ok_ff;
            rsp_last_in = 1'b1;
         end else begin
            rsp_sym_in  = job_sym_ff;
            rsp_par_in  = 1'b0;
            rsp_chk_in  = 1'b0;
            rsp_last_in = !job_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_vld_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_vld_ff   <= job_vld_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // job payload and parity shift line, highest symbol leaves first
   always_ff @(posedge clock) begin
      if (load) begin
         job_act_ff  <= q_rd_data[rgpc_pkg::JOB_ACT];
         job_last_ff <= q_rd_data[rgpc_pkg::JOB_LAST];
         job_ok_ff   <= q_rd_data[rgpc_pkg::JOB_OK];
         job_sym_ff  <= q_rd_data[rgpc_pkg::JOB_SYM_LSB +: SB];
         for (int i = 0; i < PARITY_SYMBOLS; i++) begin
            par_ff[i] <= q_rd_data[rgpc_pkg::JOB_HEAD_BITS + SB*i +: SB];
         end
      end else if (emit && idx_ff != '0) begin
         par_ff[0] <= '0;
         for (int i = 1; i < PARITY_SYMBOLS; i++) begin
            par_ff[i] <= par_ff[i-1];
         end
      end
      rsp_sym_ff  <= rsp_sym_in;
      rsp_par_ff  <= rsp_par_in;
      rsp_chk_ff  <= rsp_chk_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol_out  = rsp_sym_ff;
   assign rsp_is_parity   = rsp_par_ff;
   assign rsp_check_valid = rsp_chk_ff;
   assign rsp_last_out    = rsp_last_ff;

   `RGPC_ASSERT(a_parity_job, clock, reset, par_step |-> has_parity, "stray parity step")
   `RGPC_ASSERT_ALWAYS(a_idx_range, clock, reset || idx_ff <= IDX_LAST, "parity index out of range")
   `RGPC_ASSERT(a_final_parity, clock, reset, final_par |=> (rsp_last_ff && rsp_par_ff), "last parity unmarked")

endmodule

`default_nettype wire
